FILE: design/avds_pkg.sv
package avds_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 20;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_ENABLE    = 3'd0,
        REG_INTERVAL  = 3'd1,
        REG_DOWN_STEP = 3'd2,
        REG_UP_STEP   = 3'd3,
        REG_HOLD      = 3'd4,
        REG_RETRY     = 3'd5
    } t_reg_index;

    localparam logic        ResetEnable   = 1'b1;
    localparam logic [5:0]  ResetInterval = 6'd15;
    localparam logic [9:0]  ResetDownStep = 10'd50;
    localparam logic [9:0]  ResetUpStep   = 10'd80;
    localparam logic [15:0] ResetHold     = 16'd4500;
    localparam logic [19:0] ResetRetry    = 20'd120000;
    localparam logic [15:0] NoStation     = 16'hFFFF;

    localparam logic [13:0] MinYear   = 14'd2020;
    localparam logic [5:0]  MaxSecond = 6'd2;

    // remainder passes over two divisor shifts per cycle
    localparam int DivCycles = 3;

    typedef struct packed {
        logic       capture;
        logic       div_step;
        logic [1:0] div_cnt;
        logic       commit;
    } t_cmd;

    // one restoring step: subtract divisor << k when it fits
    function automatic logic [5:0] rem_step(input logic [5:0] rem, input logic [5:0] dv,
                                            input logic [2:0] k);
        logic [11:0] d;
        d = {6'd0, dv} << k;
        if ({6'd0, rem} >= d) begin
            return rem - d[5:0];
        end
        return rem;
    endfunction

endpackage

FILE: design/avds_ctrl.sv
module avds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output avds_pkg::t_cmd o_cmd
);
    import avds_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       commit;

    assign commit = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIV;
                    n_cnt   = 2'd0;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'(DivCycles - 1)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.capture  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.div_step = (r_state == ST_DIV);
    assign o_cmd.div_cnt  = r_cnt;
    assign o_cmd.commit   = commit;

endmodule

FILE: design/avds_dp.sv
module avds_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  avds_pkg::t_cmd                       i_cmd,
    input  logic                                 i_cfg_write,
    input  logic [avds_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [avds_pkg::CfgDataWidth-1:0]    i_cfg_data,
    input  logic [31:0]                          i_now_ms,
    input  logic                                 i_time_known,
    input  logic [13:0]                          i_year,
    input  logic [4:0]                           i_hour,
    input  logic [5:0]                           i_minute,
    input  logic [5:0]                           i_second,
    input  logic                                 i_sd_mode,
    input  logic                                 i_player_running,
    input  logic [7:0]                           i_player_volume,
    input  logic [15:0]                          i_current_station,
    output logic                                 o_volume_write,
    output logic [7:0]                           o_volume_value,
    output logic                                 o_announce,
    output logic [4:0]                           o_announce_hour,
    output logic [5:0]                           o_announce_minute,
    output logic                                 o_resume,
    output logic [15:0]                          o_resume_station,
    output logic                                 o_time_error
);
    import avds_pkg::*;

    // configuration
    logic        r_enable;
    logic [5:0]  r_interval;
    logic [9:0]  r_down_step, r_up_step;
    logic [15:0] r_hold;
    logic [19:0] r_retry;

    // captured item
    logic [31:0] r_now;
    logic        r_time_known, r_sd_mode, r_running;
    logic [13:0] r_year;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute, r_second, r_rem;
    logic [7:0]  r_pvol;
    logic [15:0] r_station;

    // sequencer state
    logic        r_fading_down, r_fading_up, r_announcing, r_level_valid, r_spoken_valid;
    logic [7:0]  r_fade_level, r_saved_volume;
    logic [5:0]  r_spoken_minute;
    logic [15:0] r_saved_station;
    logic [31:0] r_step_time, r_announce_time, r_error_time;

    logic        n_fading_down, n_fading_up, n_announcing, n_level_valid, n_spoken_valid;
    logic [7:0]  n_fade_level, n_saved_volume;
    logic [5:0]  n_spoken_minute;
    logic [15:0] n_saved_station;
    logic [31:0] n_step_time, n_announce_time, n_error_time;

    logic        vw, ann, res, terr;
    logic [7:0]  vv;
    logic [4:0]  ah;
    logic [5:0]  am;
    logic [15:0] rs;

    logic [2:0]  k_hi, k_lo;
    logic [31:0] base, diff, limit;
    logic        over;
    logic [7:0]  lvl, lvl2, sv;
    logic        step, new_minute;

    assign k_hi = 3'd5 - {i_cmd.div_cnt, 1'b0};
    assign k_lo = k_hi - 3'd1;

    // one elapsed-time compare shared by the fade, hold and retry checks
    always_comb begin
        if (r_fading_down || r_fading_up) begin
            base  = r_step_time;
            limit = r_fading_down ? {22'd0, r_down_step} : {22'd0, r_up_step};
        end else if (r_time_known) begin
            base  = r_announce_time;
            limit = {16'd0, r_hold};
        end else begin
            base  = r_error_time;
            limit = {12'd0, r_retry};
        end
        diff = r_now - base;
        over = diff > limit;
    end

    always_comb begin
        n_fading_down   = r_fading_down;
        n_fading_up     = r_fading_up;
        n_announcing    = r_announcing;
        n_level_valid   = r_level_valid;
        n_spoken_valid  = r_spoken_valid;
        n_fade_level    = r_fade_level;
        n_saved_volume  = r_saved_volume;
        n_spoken_minute = r_spoken_minute;
        n_saved_station = r_saved_station;
        n_step_time     = r_step_time;
        n_announce_time = r_announce_time;
        n_error_time    = r_error_time;
        vw   = 1'b0;
        vv   = 8'd0;
        ann  = 1'b0;
        ah   = 5'd0;
        am   = 6'd0;
        res  = 1'b0;
        rs   = 16'd0;
        terr = 1'b0;
        lvl  = 8'd0;
        lvl2 = 8'd0;
        sv   = 8'd0;
        step = 1'b0;
        new_minute = !r_spoken_valid || (r_minute != r_spoken_minute);

        if (r_enable && !r_sd_mode) begin
            if (r_fading_down) begin
                lvl  = r_level_valid ? r_fade_level : r_pvol;
                sv   = r_level_valid ? r_saved_volume : r_pvol;
                step = over && (lvl != 8'd0);
                lvl2 = step ? lvl - 8'd1 : lvl;
                n_fade_level   = lvl2;
                n_saved_volume = sv;
                n_level_valid  = 1'b1;
                if (step) begin
                    vw = 1'b1;
                    vv = lvl2;
                    n_step_time = r_now;
                end
                if (lvl2 == 8'd0) begin
                    // bottom reached: restore level and speak
                    n_saved_station = r_station;
                    vw  = 1'b1;
                    vv  = sv;
                    ann = 1'b1;
                    ah  = r_hour;
                    am  = r_minute;
                    n_announce_time = r_now;
                    n_fading_down   = 1'b0;
                    n_announcing    = 1'b1;
                    n_spoken_minute = r_minute;
                    n_spoken_valid  = 1'b1;
                    n_level_valid   = 1'b0;
                end
            end else if (r_fading_up) begin
                lvl  = r_level_valid ? r_fade_level : 8'd0;
                step = over && (lvl < r_saved_volume);
                lvl2 = step ? lvl + 8'd1 : lvl;
                n_fade_level  = lvl2;
                n_level_valid = 1'b1;
                if (step) begin
                    vw = 1'b1;
                    vv = lvl2;
                    n_step_time = r_now;
                end
                if (lvl2 >= r_saved_volume) begin
                    vw = 1'b1;
                    vv = r_saved_volume;
                    n_fading_up   = 1'b0;
                    n_level_valid = 1'b0;
                end
            end else if (r_time_known) begin
                if (r_year >= MinYear) begin
                    if (r_rem == 6'd0 && new_minute && r_second < MaxSecond &&
                        !r_announcing && r_running) begin
                        n_fading_down = 1'b1;
                        n_step_time   = r_now;
                    end else if (r_announcing && over) begin
                        res = 1'b1;
                        rs  = r_saved_station;
                        n_fading_up  = 1'b1;
                        n_step_time  = r_now;
                        n_announcing = 1'b0;
                    end
                end
            end else if (over) begin
                terr = 1'b1;
                n_error_time = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= ResetEnable;
            r_interval  <= ResetInterval;
            r_down_step <= ResetDownStep;
            r_up_step   <= ResetUpStep;
            r_hold      <= ResetHold;
            r_retry     <= ResetRetry;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                REG_ENABLE:    r_enable <= i_cfg_data[0];
                REG_INTERVAL: begin
                    if (i_cfg_data[5:0] != 6'd0) begin
                        r_interval <= i_cfg_data[5:0];
                    end
                end
                REG_DOWN_STEP: r_down_step <= i_cfg_data[9:0];
                REG_UP_STEP:   r_up_step   <= i_cfg_data[9:0];
                REG_HOLD:      r_hold      <= i_cfg_data[15:0];
                REG_RETRY:     r_retry     <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fading_down   <= 1'b0;
            r_fading_up     <= 1'b0;
            r_announcing    <= 1'b0;
            r_level_valid   <= 1'b0;
            r_spoken_valid  <= 1'b0;
            r_fade_level    <= 8'd0;
            r_saved_volume  <= 8'd0;
            r_spoken_minute <= 6'd0;
            r_saved_station <= NoStation;
            r_step_time     <= 32'd0;
            r_announce_time <= 32'd0;
            r_error_time    <= 32'd0;
        end else if (i_cmd.commit) begin
            r_fading_down   <= n_fading_down;
            r_fading_up     <= n_fading_up;
            r_announcing    <= n_announcing;
            r_level_valid   <= n_level_valid;
            r_spoken_valid  <= n_spoken_valid;
            r_fade_level    <= n_fade_level;
            r_saved_volume  <= n_saved_volume;
            r_spoken_minute <= n_spoken_minute;
            r_saved_station <= n_saved_station;
            r_step_time     <= n_step_time;
            r_announce_time <= n_announce_time;
            r_error_time    <= n_error_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now        <= i_now_ms;
            r_time_known <= i_time_known;
            r_year       <= i_year;
            r_hour       <= i_hour;
            r_minute     <= i_minute;
            r_second     <= i_second;
            r_sd_mode    <= i_sd_mode;
            r_running    <= i_player_running;
            r_pvol       <= i_player_volume;
            r_station    <= i_current_station;
            r_rem        <= i_minute;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_step(rem_step(r_rem, r_interval, k_hi), r_interval, k_lo);
        end
        if (i_cmd.commit) begin
            o_volume_write    <= vw;
            o_volume_value    <= vv;
            o_announce        <= ann;
            o_announce_hour   <= ah;
            o_announce_minute <= am;
            o_resume          <= res;
            o_resume_station  <= rs;
            o_time_error      <= terr;
        end
    end

endmodule

FILE: design/announce_volume_duck_sequencer.sv
// One item is in flight at a time: ready stays low until its result is loaded.
// The minute-modulo-interval remainder is found in the divide state (two
// restoring steps per cycle), then the evaluate state runs the sequencer and
// loads the result register; ready returns as the block goes back to idle.
// A new item is accepted while the previous result still waits in that register;
// it then waits in the evaluate cycle until the waiting result is taken.
// Reset (synchronous, active low) loads register defaults and clears the control
// and sequencer state, not the captured item or result fields; no clearing pass.
module announce_volume_duck_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [avds_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [avds_pkg::CfgDataWidth-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [31:0]                        i_now_ms,
    input  logic                               i_time_known,
    input  logic [13:0]                        i_year,
    input  logic [4:0]                         i_hour,
    input  logic [5:0]                         i_minute,
    input  logic [5:0]                         i_second,
    input  logic                               i_sd_mode,
    input  logic                               i_player_running,
    input  logic [7:0]                         i_player_volume,
    input  logic [15:0]                        i_current_station,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_volume_write,
    output logic [7:0]                         o_volume_value,
    output logic                               o_announce,
    output logic [4:0]                         o_announce_hour,
    output logic [5:0]                         o_announce_minute,
    output logic                               o_resume,
    output logic [15:0]                        o_resume_station,
    output logic                               o_time_error
);
    import avds_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    avds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    avds_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_write       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_now_ms          (i_now_ms),
        .i_time_known      (i_time_known),
        .i_year            (i_year),
        .i_hour            (i_hour),
        .i_minute          (i_minute),
        .i_second          (i_second),
        .i_sd_mode         (i_sd_mode),
        .i_player_running  (i_player_running),
        .i_player_volume   (i_player_volume),
        .i_current_station (i_current_station),
        .o_volume_write    (o_volume_write),
        .o_volume_value    (o_volume_value),
        .o_announce        (o_announce),
        .o_announce_hour   (o_announce_hour),
        .o_announce_minute (o_announce_minute),
        .o_resume          (o_resume),
        .o_resume_station  (o_resume_station),
        .o_time_error      (o_time_error)
    );

endmodule

FILE: design/avds_checker.sv
module avds_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_volume_write,
    input logic [7:0]                         o_volume_value,
    input logic                               o_announce,
    input logic [4:0]                         o_announce_hour,
    input logic [5:0]                         o_announce_minute,
    input logic                               o_resume,
    input logic [15:0]                        o_resume_station,
    input logic                               o_time_error
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while busy");

    // every announcement carries the restore write
    a_ann_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_announce |-> o_volume_write && !o_resume && !o_time_error)
        else $error("announcement without volume restore");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_volume_write || o_volume_value == 8'd0) &&
                        (o_announce || (o_announce_hour == 5'd0 &&
                                        o_announce_minute == 6'd0)) &&
                        (o_resume || o_resume_station == 16'd0))
        else $error("unused result field not zero");

endmodule

bind announce_volume_duck_sequencer avds_checker u_avds_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

import avds_pkg::*;

typedef struct packed {
    logic [31:0] now_ms;
    logic        time_known;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        sd_mode;
    logic        player_running;
    logic [7:0]  player_volume;
    logic [15:0] current_station;
} tick_t;

typedef struct packed {
    logic        volume_write;
    logic [7:0]  volume_value;
    logic        announce;
    logic [4:0]  announce_hour;
    logic [5:0]  announce_minute;
    logic        resume;
    logic [15:0] resume_station;
    logic        time_error;
} duck_result_t;

class duck_scoreboard;
    logic        cfg_enable;
    logic [5:0]  cfg_interval;
    logic [9:0]  cfg_down;
    logic [9:0]  cfg_up;
    logic [15:0] cfg_hold;
    logic [19:0] cfg_retry;

    logic        fading_down, fading_up, announcing, level_set, said_valid;
    logic [7:0]  fade_level, saved_vol;
    logic [5:0]  said_minute;
    logic [15:0] saved_station;
    logic [31:0] step_ms, announce_ms, error_ms;

    duck_result_t expected_q[$];
    int errors;

    function new();
        cfg_enable    = ResetEnable;
        cfg_interval  = ResetInterval;
        cfg_down      = ResetDownStep;
        cfg_up        = ResetUpStep;
        cfg_hold      = ResetHold;
        cfg_retry     = ResetRetry;
        fading_down   = 1'b0;
        fading_up     = 1'b0;
        announcing    = 1'b0;
        level_set     = 1'b0;
        said_valid    = 1'b0;
        fade_level    = '0;
        saved_vol     = '0;
        said_minute   = '0;
        saved_station = NoStation;
        step_ms       = '0;
        announce_ms   = '0;
        error_ms      = '0;
        errors        = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] data);
        case (idx)
            REG_ENABLE:    cfg_enable = data[0];
            REG_INTERVAL: begin
                // zero interval is dropped, register keeps its value
                if (data[5:0] != 6'd0) cfg_interval = data[5:0];
            end
            REG_DOWN_STEP: cfg_down  = data[9:0];
            REG_UP_STEP:   cfg_up    = data[9:0];
            REG_HOLD:      cfg_hold  = data[15:0];
            REG_RETRY:     cfg_retry = data[19:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // advance the sequencer by one tick and queue the expected outputs
    function void note_tick(tick_t t);
        duck_result_t r;
        logic [31:0]  since_step, since_ann, since_err;
        logic         new_minute;
        r          = '0;
        since_step = t.now_ms - step_ms;
        since_ann  = t.now_ms - announce_ms;
        since_err  = t.now_ms - error_ms;
        new_minute = !said_valid || (t.minute != said_minute);
        if (cfg_enable && !t.sd_mode) begin
            if (fading_down) begin
                if (!level_set) begin
                    fade_level = t.player_volume;
                    saved_vol  = t.player_volume;
                    level_set  = 1'b1;
                end
                if (since_step > 32'(cfg_down) && fade_level != 8'd0) begin
                    fade_level     = fade_level - 8'd1;
                    r.volume_write = 1'b1;
                    r.volume_value = fade_level;
                    step_ms        = t.now_ms;
                end
                if (fade_level == 8'd0) begin
                    saved_station     = t.current_station;
                    r.volume_write    = 1'b1;
                    r.volume_value    = saved_vol;
                    r.announce        = 1'b1;
                    r.announce_hour   = t.hour;
                    r.announce_minute = t.minute;
                    announce_ms       = t.now_ms;
                    fading_down       = 1'b0;
                    announcing        = 1'b1;
                    said_minute       = t.minute;
                    said_valid        = 1'b1;
                    level_set         = 1'b0;
                end
            end else if (fading_up) begin
                if (!level_set) begin
                    fade_level = 8'd0;
                    level_set  = 1'b1;
                end
                if (since_step > 32'(cfg_up) && fade_level < saved_vol) begin
                    fade_level     = fade_level + 8'd1;
                    r.volume_write = 1'b1;
                    r.volume_value = fade_level;
                    step_ms        = t.now_ms;
                end
                if (fade_level >= saved_vol) begin
                    r.volume_write = 1'b1;
                    r.volume_value = saved_vol;
                    fading_up      = 1'b0;
                    level_set      = 1'b0;
                end
            end else if (t.time_known) begin
                if (t.year >= MinYear) begin
                    if ((t.minute % cfg_interval) == 6'd0 && new_minute &&
                        t.second < MaxSecond && !announcing && t.player_running) begin
                        fading_down = 1'b1;
                        step_ms     = t.now_ms;
                    end else if (announcing && since_ann > 32'(cfg_hold)) begin
                        r.resume         = 1'b1;
                        r.resume_station = saved_station;
                        fading_up        = 1'b1;
                        step_ms          = t.now_ms;
                        announcing       = 1'b0;
                    end
                end
            end else if (since_err > 32'(cfg_retry)) begin
                r.time_error = 1'b1;
                error_ms     = t.now_ms;
            end
        end
        expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(duck_result_t got);
        duck_result_t e;
        if (expected_q.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
            return;
        end
        e = expected_q.pop_front();
        cmp("volume_write",    32'(e.volume_write),    32'(got.volume_write));
        cmp("volume_value",    32'(e.volume_value),    32'(got.volume_value));
        cmp("announce",        32'(e.announce),        32'(got.announce));
        cmp("announce_hour",   32'(e.announce_hour),   32'(got.announce_hour));
        cmp("announce_minute", 32'(e.announce_minute), 32'(got.announce_minute));
        cmp("resume",          32'(e.resume),          32'(got.resume));
        cmp("resume_station",  32'(e.resume_station),  32'(got.resume_station));
        cmp("time_error",      32'(e.time_error),      32'(got.time_error));
    endfunction
endclass

module tb_top;

    localparam int CycleLimit    = 400000;
    localparam int DrainCycles   = 8;
    localparam int HoldOffCycles = 300;
    localparam int PhaseItems    = 245;
    localparam int IdlePhaseItems = 40;
    localparam logic [2:0] RegSpare0 = 3'd6;
    localparam logic [2:0] RegSpare1 = 3'd7;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CfgIndexWidth-1:0] i_cfg_index;
    logic [CfgDataWidth-1:0]  i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [31:0]              i_now_ms;
    logic                     i_time_known;
    logic [13:0]              i_year;
    logic [4:0]               i_hour;
    logic [5:0]               i_minute;
    logic [5:0]               i_second;
    logic                     i_sd_mode;
    logic                     i_player_running;
    logic [7:0]               i_player_volume;
    logic [15:0]              i_current_station;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic                     o_volume_write;
    logic [7:0]               o_volume_value;
    logic                     o_announce;
    logic [4:0]               o_announce_hour;
    logic [5:0]               o_announce_minute;
    logic                     o_resume;
    logic [15:0]              o_resume_station;
    logic                     o_time_error;

    duck_scoreboard sb;
    logic [31:0]    sim_ms;
    bit             no_idle;
    bit             hold_off_req;
    bit             rst_done;
    int             cycle_count;

    announce_volume_duck_sequencer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_now_ms          (i_now_ms),
        .i_time_known      (i_time_known),
        .i_year            (i_year),
        .i_hour            (i_hour),
        .i_minute          (i_minute),
        .i_second          (i_second),
        .i_sd_mode         (i_sd_mode),
        .i_player_running  (i_player_running),
        .i_player_volume   (i_player_volume),
        .i_current_station (i_current_station),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_volume_write    (o_volume_write),
        .o_volume_value    (o_volume_value),
        .o_announce        (o_announce),
        .o_announce_hour   (o_announce_hour),
        .o_announce_minute (o_announce_minute),
        .o_resume          (o_resume),
        .o_resume_station  (o_resume_station),
        .o_time_error      (o_time_error)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic tick_t mk_tick(logic [31:0] now, logic known, logic [13:0] yr,
                                      logic [4:0] hr, logic [5:0] mn, logic [5:0] sec,
                                      logic sd, logic run, logic [7:0] vol,
                                      logic [15:0] stn);
        tick_t t;
        t.now_ms          = now;
        t.time_known      = known;
        t.year            = yr;
        t.hour            = hr;
        t.minute          = mn;
        t.second          = sec;
        t.sd_mode         = sd;
        t.player_running  = run;
        t.player_volume   = vol;
        t.current_station = stn;
        return t;
    endfunction

    // mostly plausible clock advance and trigger-friendly wall-clock fields
    function automatic tick_t rand_tick();
        tick_t       t;
        int unsigned r, span, jump, iv, k;
        r    = $urandom_range(0, 99);
        span = (sb.cfg_down > sb.cfg_up) ? 32'(sb.cfg_down) : 32'(sb.cfg_up);
        span = 2 * span + 4;
        jump = 32'(sb.cfg_hold) + 2000;
        if (r < 2)       sim_ms = $urandom();
        else if (r < 12) sim_ms = sim_ms + $urandom_range(0, jump);
        else if (r < 20) sim_ms = sim_ms + $urandom_range(0, 2);
        else             sim_ms = sim_ms + $urandom_range(0, span);
        t.now_ms     = sim_ms;
        t.time_known = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) == 0) t.year = 14'($urandom_range(0, 16383));
        else                           t.year = 14'($urandom_range(2020, 2099));
        t.hour = 5'($urandom_range(0, 31));
        iv = 32'(sb.cfg_interval);
        if ($urandom_range(0, 9) < 6) begin
            k        = $urandom_range(0, 59 / iv);
            t.minute = 6'(k * iv);
        end else begin
            t.minute = 6'($urandom_range(0, 63));
        end
        if ($urandom_range(0, 9) < 6) t.second = 6'($urandom_range(0, 1));
        else                          t.second = 6'($urandom_range(0, 63));
        t.sd_mode        = ($urandom_range(0, 19) == 0);
        t.player_running = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 11) == 0) t.player_volume = 8'($urandom_range(0, 255));
        else                            t.player_volume = 8'($urandom_range(0, 6));
        t.current_station = 16'($urandom());
        return t;
    endfunction

    task automatic push_tick(tick_t t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_now_ms          <= t.now_ms;
        i_time_known      <= t.time_known;
        i_year            <= t.year;
        i_hour            <= t.hour;
        i_minute          <= t.minute;
        i_second          <= t.second;
        i_sd_mode         <= t.sd_mode;
        i_player_running  <= t.player_running;
        i_player_volume   <= t.player_volume;
        i_current_station <= t.current_station;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_tick(t);
    endtask

    // leaves valid high; caller lowers it after the last write of a batch
    task automatic cfg_write(logic [2:0] idx, logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int           stall;
        duck_result_t got;
        i_out_ready <= 1'b0;
        wait (rst_done);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = HoldOffCycles;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            got.volume_write    = o_volume_write;
            got.volume_value    = o_volume_value;
            got.announce        = o_announce;
            got.announce_hour   = o_announce_hour;
            got.announce_minute = o_announce_minute;
            got.resume          = o_resume;
            got.resume_station  = o_resume_station;
            got.time_error      = o_time_error;
            @(posedge i_clk);
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : main_seq
        int          ph, n, items;
        logic [19:0] v_en, v_iv, v_dn, v_up, v_hold, v_retry;
        sb           = new();
        sim_ms       = '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        rst_done     = 1'b0;
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_now_ms          <= '0;
        i_time_known      <= 1'b0;
        i_year            <= '0;
        i_hour            <= '0;
        i_minute          <= '0;
        i_second          <= '0;
        i_sd_mode         <= 1'b0;
        i_player_running  <= 1'b0;
        i_player_volume   <= '0;
        i_current_station <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        // directed pass on reset defaults
        push_tick(mk_tick(32'd200000, 0, 14'd2020, 0, 0, 0, 0, 1, 0, 0));   // time error
        push_tick(mk_tick(32'd200001, 0, 14'd2020, 0, 0, 0, 0, 1, 0, 0));   // within retry
        push_tick(mk_tick(32'd500000, 0, 14'd2020, 0, 0, 0, 1, 1, 0, 0));   // card mode
        push_tick(mk_tick(32'd500000, 1, 14'd2019, 12, 15, 0, 0, 1, 100, 5));
        push_tick(mk_tick(32'd500000, 1, 14'd2020, 12, 15, 2, 0, 1, 100, 5));
        push_tick(mk_tick(32'd500000, 1, 14'd2020, 12, 16, 0, 0, 1, 100, 5));
        push_tick(mk_tick(32'd500000, 1, 14'd2020, 12, 15, 0, 0, 0, 100, 5));
        push_tick(mk_tick(32'd500000, 1, 14'd16383, 31, 0, 1, 0, 1, 2, 16'hFFFF));
        // fade down ignores time fields
        push_tick(mk_tick(32'd500051, 0, 14'd0, 0, 0, 0, 0, 0, 2, 0));
        push_tick(mk_tick(32'd500101, 0, 14'd0, 0, 0, 0, 0, 0, 200, 0));
        push_tick(mk_tick(32'd500102, 0, 14'd0, 23, 59, 63, 0, 0, 200, 16'hABCD));
        push_tick(mk_tick(32'd504602, 1, 14'd2020, 0, 0, 0, 0, 1, 9, 0));   // hold not over
        push_tick(mk_tick(32'd504603, 1, 14'd2020, 0, 0, 0, 0, 1, 9, 0));   // resume
        push_tick(mk_tick(32'd504683, 1, 14'd2020, 0, 0, 0, 0, 1, 9, 0));
        push_tick(mk_tick(32'd504684, 1, 14'd2020, 0, 0, 0, 0, 1, 9, 0));
        push_tick(mk_tick(32'd504765, 1, 14'd2020, 0, 0, 0, 0, 1, 9, 0));
        // zero captured volume announces on the first fade tick
        push_tick(mk_tick(32'd504765, 1, 14'd2020, 1, 30, 1, 0, 1, 0, 7));
        push_tick(mk_tick(32'd504766, 1, 14'd2020, 17, 30, 1, 0, 1, 0, 16'h0000));
        push_tick(mk_tick(32'hFFFF_FFFF, 1, 14'd9999, 2, 1, 0, 0, 1, 8'hFF, 16'hFFFF));
        push_tick(mk_tick(32'h0000_0010, 1, 14'd9999, 2, 1, 0, 0, 1, 8'hFF, 16'hFFFF));
        push_tick(mk_tick(32'd5, 0, 14'd0, 0, 0, 0, 0, 1, 0, 0));           // wrapped retry
        i_in_valid <= 1'b0;
        settle();

        for (ph = 0; ph < 8; ph++) begin
            v_en    = 20'd1;
            v_iv    = 20'($urandom());
            v_dn    = 20'($urandom());
            v_up    = 20'($urandom());
            v_hold  = 20'($urandom());
            v_retry = 20'($urandom());
            items   = PhaseItems;
            case (ph)
                0: begin
                    v_iv = 20'd1; v_dn = 20'd0; v_up = 20'd0; v_hold = 20'd0; v_retry = 20'd0;
                end
                1: begin
                    v_iv = 20'd60; v_dn = 20'd1023; v_up = 20'd1023;
                    v_hold = 20'd65535; v_retry = 20'hFFFFF;
                end
                2: begin
                    v_en  = 20'd0;
                    items = IdlePhaseItems;
                end
                3: v_iv = 20'd63;
                default: v_en = 20'($urandom_range(0, 7) != 0);
            endcase
            cfg_write(REG_ENABLE, v_en);
            cfg_write(REG_INTERVAL, v_iv);
            cfg_write(REG_DOWN_STEP, v_dn);
            cfg_write(REG_UP_STEP, v_up);
            cfg_write(REG_HOLD, v_hold);
            cfg_write(REG_RETRY, v_retry);
            if (ph == 3) begin
                // zero interval writes are dropped, spare indexes do nothing
                cfg_write(REG_INTERVAL, 20'd0);
                cfg_write(REG_INTERVAL, 20'hFFFC0);
                cfg_write(RegSpare0, 20'($urandom()));
                cfg_write(RegSpare1, 20'($urandom()));
            end
            i_cfg_valid <= 1'b0;
            no_idle = (ph == 4) || (ph == 6);
            if (ph == 4 || ph == 6) hold_off_req = 1'b1;
            for (n = 0; n < items; n++) push_tick(rand_tick());
            i_in_valid <= 1'b0;
            settle();
            no_idle = 1'b0;
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
